// ===== rtl/mu8h_pkg.sv =====
package mu8h_pkg;

  // Continuation bytes still owed by the character being decoded.
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;

  // Decoupling queue between decoder and accumulator (depth a power of two).
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = QueuePtrW + 1;

  // One decoded word: either a code unit to fold, or the end of a string.
  typedef struct packed {
    logic        last;
    logic [15:0] unit;
  } unit_word_t;

endpackage

// ===== rtl/mu8h_decode.sv =====
module mu8h_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           byte_i,
  input  logic                 accept_i,
  output logic                 push_o,
  output mu8h_pkg::unit_word_t word_o
);
  import mu8h_pkg::*;

  logic [1:0]  pending_q, pending_d;
  logic [15:0] partial_q, partial_d;
  logic        take;

  assign take = byte_valid_i & accept_i;

  // Classify the byte against the decoder state and build the next unit.
  always_comb begin
    pending_d   = pending_q;
    partial_d   = partial_q;
    push_o      = 1'b0;
    word_o.last = 1'b0;
    word_o.unit = '0;
    unique case (pending_q)
      PendTwo: begin
        partial_d = partial_q | {4'b0, byte_i[5:0], 6'b0};
        pending_d = PendOne;
      end
      PendOne: begin
        push_o      = 1'b1;
        word_o.unit = partial_q | {10'b0, byte_i[5:0]};
        partial_d   = '0;
        pending_d   = PendNone;
      end
      default: begin
        // Character boundary: a zero byte ends the string.
        pending_d = PendNone;
        if (byte_i == 8'h00) begin
          push_o      = 1'b1;
          word_o.last = 1'b1;
          partial_d   = '0;
        end else if (!byte_i[7]) begin
          push_o      = 1'b1;
          word_o.unit = {8'b0, byte_i};
        end else if (byte_i[5]) begin
          partial_d = {byte_i[3:0], 12'b0};
          pending_d = PendTwo;
        end else begin
          partial_d = {5'b0, byte_i[4:0], 6'b0};
          pending_d = PendOne;
        end
      end
    endcase
    push_o = push_o & take;
  end

  // Decoder state advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= PendNone;
      partial_q <= '0;
    end else if (take) begin
      pending_q <= pending_d;
      partial_q <= partial_d;
    end
  end

endmodule

// ===== rtl/mu8h_fifo.sv =====
module mu8h_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mu8h_pkg::unit_word_t push_word_i,
  output logic                 not_full_o,
  input  logic                 pop_i,
  output logic                 not_empty_o,
  output mu8h_pkg::unit_word_t pop_word_o
);
  import mu8h_pkg::*;

  unit_word_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign not_full_o  = (count_q != QueueCntW'(QueueDepth));
  assign not_empty_o = (count_q != '0);
  assign pop_word_o  = mem_q[rd_ptr_q];

  // Storage for queued words.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mu8h_accum.sv =====
module mu8h_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 word_valid_i,
  input  mu8h_pkg::unit_word_t word_i,
  output logic                 pop_o,
  output logic                 hash_valid_o,
  output logic [63:0]          hash_o,
  input  logic                 hash_ready_i
);
  import mu8h_pkg::*;

  logic [63:0] hash_q, hash_d;
  logic [63:0] hash_out_q;
  logic        out_valid_q;
  logic        slot_free;

  assign slot_free    = ~out_valid_q | hash_ready_i;
  assign pop_o        = word_valid_i & (~word_i.last | slot_free);
  assign hash_valid_o = out_valid_q;
  assign hash_o       = hash_out_q;

  // Fold one unit: hash * 37 + unit, as shifts and adds, modulo 2^64.
  always_comb begin
    hash_d = (hash_q << 5) + (hash_q << 2) + hash_q + {48'b0, word_i.unit};
  end

  // Running hash; cleared when a string ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else if (pop_o) begin
      hash_q <= word_i.last ? 64'd0 : hash_d;
    end
  end

  // Output register holding a finished hash until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && word_i.last) begin
      out_valid_q <= 1'b1;
    end else if (hash_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && word_i.last) begin
      hash_out_q <= hash_q;
    end
  end

endmodule

// ===== rtl/modified_utf8_string_hash.sv =====
// Channel      Direction  Ports                                          Word
// data_byte    in         data_byte_i, data_byte_valid_i, _ready_o       8-bit string byte
// string_hash  out        string_hash_o, string_hash_valid_o, _ready_i   64-bit hash
//
// One byte is taken per cycle while the queue is not full; the decoder and the
// add-shift multiply by 37 are combinational. A hash is registered when its zero
// byte is popped from the queue. Reset clears the decoder, the queue and the
// running hash; no other setup. A stalled output holds the hash register; the
// two-word queue then fills and input ready drops only once it is full.
module modified_utf8_string_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        data_byte_valid_i,
  output logic        data_byte_ready_o,
  output logic [63:0] string_hash_o,
  output logic        string_hash_valid_o,
  input  logic        string_hash_ready_i
);
  import mu8h_pkg::*;

  logic       push, pop, not_full, not_empty;
  unit_word_t push_word, pop_word;

  assign data_byte_ready_o = not_full;

  // Front: byte decoding.
  mu8h_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(data_byte_valid_i),
    .byte_i      (data_byte_i),
    .accept_i    (not_full),
    .push_o      (push),
    .word_o      (push_word)
  );

  // Queue between front and back.
  mu8h_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_word_i(push_word),
    .not_full_o (not_full),
    .pop_i      (pop),
    .not_empty_o(not_empty),
    .pop_word_o (pop_word)
  );

  // Back: hash accumulation and output.
  mu8h_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_valid_i(not_empty),
    .word_i      (pop_word),
    .pop_o       (pop),
    .hash_valid_o(string_hash_valid_o),
    .hash_o      (string_hash_o),
    .hash_ready_i(string_hash_ready_i)
  );

endmodule
